[rtl/spmv_pkg.sv]
// Shared types, constants and arithmetic helpers for the sparse matrix-vector block.
// No dependencies; every other file of the block but spmv_ram uses this package.
`default_nettype none

package spmv_pkg;

  // Sizes of the vector store and the fixed-point format.
  localparam int VECTOR_DEPTH  = 1024;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 32;
  localparam int ROW_W   = 16;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int CMP_W   = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_NZ    = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

  // Commands handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_MAC,
    CMD_EMPTY
  } cmd_t;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // One queued request: command, end-of-row flag, matrix value and vector element.
  typedef struct packed {
    cmd_t  cmd;
    logic  row_end;
    data_t value;
    data_t x;
  } q_entry_t;

  // Saturate a widened sum to the accumulator range.
  function automatic acc_t sat_acc(input logic signed [PROD_W:0] s);
    logic hi_same;
    hi_same = (s[PROD_W:ACC_W-1] == {(PROD_W-ACC_W+2){s[PROD_W]}});
    if (hi_same) begin
      sat_acc = s[ACC_W-1:0];
    end else if (s[PROD_W]) begin
      sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  // Clip an accumulator value to the output range; the top bit flags clipping.
  function automatic logic [DATA_W:0] clip_sum(input acc_t s);
    logic hi_same;
    hi_same = (s[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){s[ACC_W-1]}});
    if (hi_same) begin
      clip_sum = {1'b0, s[DATA_W-1:0]};
    end else if (s[ACC_W-1]) begin
      clip_sum = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      clip_sum = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

[rtl/csr_sparse_matrix_vector_multiply.sv]
// Top level of the compressed-row sparse matrix times dense vector block.
// Depends on spmv_pkg, spmv_front, spmv_queue and spmv_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | in_op, in_index, in_value, in_row_end
//   result  | out_valid/ out_ready | out_row_index, out_row_sum, out_saturated
//
// One request per cycle is sustained while the queue is not full; the vector
// store has one write and one read port, each used at most once per accepted
// request. On its way to the output a finished row passes the store read, the
// queue, the multiply and accumulate stages and the output register.
// Reset is synchronous; no clearing pass is needed, so requests are taken
// right after reset. A stalled output holds the back part; the front part
// keeps filling the queue until it is full.
`default_nettype none

module csr_sparse_matrix_vector_multiply (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [spmv_pkg::OP_W-1:0]           in_op,
  input  wire logic [spmv_pkg::INDEX_W-1:0]        in_index,
  input  wire logic signed [spmv_pkg::DATA_W-1:0]  in_value,
  input  wire logic                                in_row_end,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [spmv_pkg::ROW_W-1:0]               out_row_index,
  output logic signed [spmv_pkg::DATA_W-1:0]       out_row_sum,
  output logic                                     out_saturated
);

  import spmv_pkg::*;

  logic      push;
  q_entry_t  push_entry;
  logic      q_full;
  logic      pop;
  logic      q_not_empty;
  q_entry_t  pop_entry;

  spmv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_row_end (in_row_end),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  spmv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  spmv_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_entry       (pop_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_row_sum   (out_row_sum),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

[rtl/spmv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/spmv_front.sv]
// Front part: accepts requests, classifies them, writes and reads the vector store.
// Depends on spmv_pkg and spmv_ram.
`default_nettype none

module spmv_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [spmv_pkg::OP_W-1:0]     in_op,
  input  wire logic [spmv_pkg::INDEX_W-1:0]  in_index,
  input  wire logic signed [spmv_pkg::DATA_W-1:0] in_value,
  input  wire logic                          in_row_end,
  output logic                               push,
  output spmv_pkg::q_entry_t                 push_entry,
  input  wire logic                          q_full
);

  import spmv_pkg::*;

  logic               accept;
  logic [CMP_W-1:0]   idx_cmp;
  logic [ADDR_W-1:0]  addr;
  logic               in_range;
  logic               keep;
  cmd_t               cmd;
  logic [DATA_W-1:0]  rd_data;

  logic               s1_valid_r, s1_valid_nxt;
  cmd_t               s1_cmd_r;
  logic               s1_row_end_r;
  data_t              s1_value_r;
  logic               s1_col_ok_r;

  // The stage frees up when it is empty or its request moves into the queue.
  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  // Address decode; columns past the store read as zero and loads there are dropped.
  assign idx_cmp  = CMP_W'(in_index);
  assign addr     = idx_cmp[ADDR_W-1:0];
  assign in_range = (idx_cmp < CMP_W'(VECTOR_DEPTH));

  // Classify the request; the unused opcode is dropped.
  always_comb begin
    keep = 1'b1;
    cmd  = CMD_CLEAR;
    unique case (in_op)
      OP_LOAD:  cmd = CMD_CLEAR;
      OP_NZ:    cmd = CMD_MAC;
      OP_EMPTY: cmd = CMD_EMPTY;
      default:  keep = 1'b0;
    endcase
  end

  spmv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (accept && (in_op == OP_LOAD) && in_range),
    .waddr (addr),
    .wdata (in_value),
    .re    (accept && (in_op == OP_NZ)),
    .raddr (addr),
    .rdata (rd_data)
  );

  // Stage valid follows accepted requests.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage payload; the store's registered read data lines up with it.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r     <= cmd;
      s1_row_end_r <= in_row_end;
      s1_value_r   <= in_value;
      s1_col_ok_r  <= in_range;
    end
  end

  // Hand the request to the queue.
  assign push               = s1_valid_r && !q_full;
  assign push_entry.cmd     = s1_cmd_r;
  assign push_entry.row_end = s1_row_end_r;
  assign push_entry.value   = s1_value_r;
  assign push_entry.x       = s1_col_ok_r ? data_t'(rd_data) : '0;

endmodule

`default_nettype wire

[rtl/spmv_queue.sv]
// Short queue that decouples the front part from the back part.
// Depends on spmv_pkg.
`default_nettype none

module spmv_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire spmv_pkg::q_entry_t  push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output spmv_pkg::q_entry_t       pop_entry
);

  import spmv_pkg::*;

  q_entry_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef NO_ASSERTIONS
  // A push alone raises the fill count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill count did not follow a push");
`endif

endmodule

`default_nettype wire

[rtl/spmv_back.sv]
// Back part: multiplies, accumulates per row and presents finished rows.
// Depends on spmv_pkg.
`default_nettype none

module spmv_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_not_empty,
  input  wire spmv_pkg::q_entry_t             q_entry,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [spmv_pkg::ROW_W-1:0]          out_row_index,
  output logic signed [spmv_pkg::DATA_W-1:0]  out_row_sum,
  output logic                                out_saturated
);

  import spmv_pkg::*;

  logic                       adv;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W:0]     sum_w;
  acc_t                       sum_sat;
  logic [DATA_W:0]            clipped;

  // Multiply stage.
  logic                       b1_valid_r, b1_valid_nxt;
  cmd_t                       b1_cmd_r;
  logic                       b1_row_end_r;
  logic signed [PROD_W-1:0]   b1_prod_r;

  // Accumulate stage and the pending result.
  acc_t                       acc_r, acc_nxt;
  logic [ROW_W-1:0]           row_cnt_r, row_cnt_nxt;
  logic                       res_valid_r, res_valid_nxt;
  acc_t                       res_sum_r, res_sum_nxt;
  logic [ROW_W-1:0]           res_row_r, res_row_nxt;

  // Output register.
  logic                       out_valid_r;
  logic [ROW_W-1:0]           out_row_r;
  data_t                      out_sum_r;
  logic                       out_sat_r;

  // The whole back pipeline moves when the output register can take a result.
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && q_not_empty;

  // Full product, floor-shifted to the fixed-point scale.
  assign prod = (PROD_W'(q_entry.value) * PROD_W'(q_entry.x)) >>> FRACTION_BITS;

  always_comb begin
    b1_valid_nxt = adv ? q_not_empty : b1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_cmd_r     <= q_entry.cmd;
      b1_row_end_r <= q_entry.row_end;
      b1_prod_r    <= prod;
    end
  end

  // Accumulate with saturation, finish rows and count them.
  assign sum_w   = {{(PROD_W-ACC_W+1){acc_r[ACC_W-1]}}, acc_r} + {b1_prod_r[PROD_W-1], b1_prod_r};
  assign sum_sat = sat_acc(sum_w);

  always_comb begin
    acc_nxt       = acc_r;
    row_cnt_nxt   = row_cnt_r;
    res_valid_nxt = res_valid_r;
    res_sum_nxt   = res_sum_r;
    res_row_nxt   = res_row_r;
    if (adv) begin
      res_valid_nxt = 1'b0;
      if (b1_valid_r) begin
        unique case (b1_cmd_r)
          CMD_CLEAR: begin
            acc_nxt     = '0;
            row_cnt_nxt = '0;
          end
          CMD_MAC: begin
            if (b1_row_end_r) begin
              acc_nxt       = '0;
              res_valid_nxt = 1'b1;
              res_sum_nxt   = sum_sat;
              res_row_nxt   = row_cnt_r;
              row_cnt_nxt   = row_cnt_r + 1'b1;
            end else begin
              acc_nxt = sum_sat;
            end
          end
          CMD_EMPTY: begin
            acc_nxt       = '0;
            res_valid_nxt = 1'b1;
            res_sum_nxt   = '0;
            res_row_nxt   = row_cnt_r;
            row_cnt_nxt   = row_cnt_r + 1'b1;
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      row_cnt_r   <= '0;
    end else begin
      b1_valid_r  <= b1_valid_nxt;
      res_valid_r <= res_valid_nxt;
      acc_r       <= acc_nxt;
      row_cnt_r   <= row_cnt_nxt;
      if (adv) begin
        out_valid_r <= res_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_sum_r <= res_sum_nxt;
    res_row_r <= res_row_nxt;
  end

  // Clip the row sum into the output register.
  assign clipped = clip_sum(res_sum_r);

  always_ff @(posedge clk) begin
    if (adv && res_valid_r) begin
      out_row_r <= res_row_r;
      out_sum_r <= clipped[DATA_W-1:0];
      out_sat_r <= clipped[DATA_W];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_row_sum   = out_sum_r;
  assign out_saturated = out_sat_r;

`ifndef NO_ASSERTIONS
  // A processed clear restarts the row count and empties the accumulator.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && b1_valid_r && b1_cmd_r == CMD_CLEAR |=> row_cnt_r == '0 && acc_r == '0)
    else $error("clear did not reset the row state");

  // A finished row leaves the accumulator empty and advances the row count.
  a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
    adv && b1_valid_r && (b1_cmd_r == CMD_EMPTY || (b1_cmd_r == CMD_MAC && b1_row_end_r))
    |=> acc_r == '0 && row_cnt_r == $past(row_cnt_r) + 1'b1 && res_valid_r)
    else $error("finished row not handled");

  // A pending result only appears from a row-finishing command.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(b1_valid_r) &&
      ($past(b1_cmd_r) == CMD_EMPTY || ($past(b1_cmd_r) == CMD_MAC && $past(b1_row_end_r))))
    else $error("result without a finished row");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for csr_sparse_matrix_vector_multiply: random and directed requests
// are checked against a shadow model of the vector store, accumulator and row counter.
// Depends on spmv_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;

  // Opcode the block must ignore.
  localparam logic [spmv_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int          RANDOM_REQUESTS = 1300;
  localparam int          HOLD_AFTER_ROWS = 40;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int          REPORT_LIMIT    = 50;
  localparam longint      ACC_HI = (longint'(1) << (spmv_pkg::ACC_W - 1)) - 1;
  localparam longint      ACC_LO = -(longint'(1) << (spmv_pkg::ACC_W - 1));
  localparam longint      SUM_HI = (longint'(1) << (spmv_pkg::DATA_W - 1)) - 1;
  localparam longint      SUM_LO = -(longint'(1) << (spmv_pkg::DATA_W - 1));

  typedef struct {
    logic [spmv_pkg::OP_W-1:0]          op;
    logic [spmv_pkg::INDEX_W-1:0]       index;
    logic signed [spmv_pkg::DATA_W-1:0] value;
    logic                               row_end;
  } spmv_req_t;

  typedef struct {
    logic [spmv_pkg::ROW_W-1:0]         row_index;
    logic signed [spmv_pkg::DATA_W-1:0] row_sum;
    logic                               saturated;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [spmv_pkg::OP_W-1:0]          in_op = spmv_pkg::OP_EMPTY;
  logic [spmv_pkg::INDEX_W-1:0]       in_index = '0;
  logic signed [spmv_pkg::DATA_W-1:0] in_value = '0;
  logic                               in_row_end = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [spmv_pkg::ROW_W-1:0]         out_row_index;
  logic signed [spmv_pkg::DATA_W-1:0] out_row_sum;
  logic                               out_saturated;

  // Stimulus and expectation stores.
  spmv_req_t   request_fifo[$];
  row_result_t expected_rows[$];
  int          total_requests = 0;
  int          taken_requests = 0;
  int          generated = 0;
  int          mismatches = 0;
  int          rows_seen = 0;

  // Shadow state of the block.
  logic signed [spmv_pkg::DATA_W-1:0] shadow_vector [spmv_pkg::VECTOR_DEPTH];
  longint                             shadow_acc = 0;
  logic [spmv_pkg::ROW_W-1:0]         shadow_row = '0;

  // Vector entries written so far by the stimulus.
  bit                           written [spmv_pkg::VECTOR_DEPTH];
  logic [spmv_pkg::INDEX_W-1:0] written_cols[$];

  // Idle control for both sides; only the quiet flag is shared by them.
  logic        quiet = 1'b0;
  int unsigned quiet_left = 100;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        hold_done = 1'b0;

  csr_sparse_matrix_vector_multiply dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_value      (in_value),
    .in_row_end    (in_row_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_row_sum   (out_row_sum),
    .out_saturated (out_saturated)
  );

  always #2 clk = ~clk;

  // Record a finished row: clip the sum to 32 bits and advance the row counter.
  function automatic void emit_row(input longint sum);
    row_result_t r;
    r.row_index = shadow_row;
    r.saturated = (sum > SUM_HI) || (sum < SUM_LO);
    if (sum > SUM_HI) begin
      r.row_sum = SUM_HI[spmv_pkg::DATA_W-1:0];
    end else if (sum < SUM_LO) begin
      r.row_sum = SUM_LO[spmv_pkg::DATA_W-1:0];
    end else begin
      r.row_sum = sum[spmv_pkg::DATA_W-1:0];
    end
    expected_rows.push_back(r);
    shadow_row = shadow_row + 1'b1;
  endfunction

  // Apply one accepted request to the shadow state and queue any finished row.
  function automatic void apply_request(input spmv_req_t req);
    longint product;
    longint total;
    case (req.op)
      spmv_pkg::OP_LOAD: begin
        shadow_vector[req.index] = req.value;
        shadow_acc = 0;
        shadow_row = '0;
      end
      spmv_pkg::OP_NZ: begin
        product = longint'(req.value) * longint'(shadow_vector[req.index]);
        total = shadow_acc + (product >>> spmv_pkg::FRACTION_BITS);
        if (total > ACC_HI) begin
          total = ACC_HI;
        end else if (total < ACC_LO) begin
          total = ACC_LO;
        end
        shadow_acc = total;
        if (req.row_end) begin
          emit_row(shadow_acc);
          shadow_acc = 0;
        end
      end
      spmv_pkg::OP_EMPTY: begin
        shadow_acc = 0;
        emit_row(0);
      end
      default: begin
      end
    endcase
  endfunction

  // Queue one request; loads mark their vector entry as readable.
  function automatic void add_request(input logic [spmv_pkg::OP_W-1:0] op,
                                      input logic [spmv_pkg::INDEX_W-1:0] index,
                                      input logic signed [spmv_pkg::DATA_W-1:0] value,
                                      input logic row_end);
    spmv_req_t req;
    req.op = op;
    req.index = index;
    req.value = value;
    req.row_end = row_end;
    request_fifo.push_back(req);
    if (op == spmv_pkg::OP_LOAD && !written[index]) begin
      written[index] = 1'b1;
      written_cols.push_back(index);
    end
    if (op != OP_UNUSED) begin
      generated++;
    end
  endfunction

  // Small Q16.16 values half the time, with full-range values and the extremes mixed in.
  function automatic logic signed [spmv_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 32'h3FFFFF)) - 32'h200000;
    endcase
  endfunction

  // Any vector position, loaded or not.
  function automatic logic [spmv_pkg::INDEX_W-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, spmv_pkg::VECTOR_DEPTH - 1);
    return r[spmv_pkg::INDEX_W-1:0];
  endfunction

  // A column that has been loaded, so no unwritten entry is ever read.
  function automatic logic [spmv_pkg::INDEX_W-1:0] pick_column();
    return written_cols[$urandom_range(0, written_cols.size() - 1)];
  endfunction

  // Idle length: usually none, sometimes short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_LIMIT) begin
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Alternate between busy stretches with idling and quiet stretches without.
  always @(posedge clk) begin
    if (quiet_left != 0) begin
      quiet_left <= quiet_left - 1;
    end else begin
      quiet <= ~quiet;
      quiet_left <= quiet ? $urandom_range(200, 600) : $urandom_range(50, 150);
    end
  end

  // Request driver: presents queued requests, with random gaps between them.
  always @(posedge clk) begin : drive_requests
    spmv_req_t next_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        next_req.op = in_op;
        next_req.index = in_index;
        next_req.value = in_value;
        next_req.row_end = in_row_end;
        apply_request(next_req);
        taken_requests++;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_fifo.size() != 0) begin
        next_req = request_fifo.pop_front();
        in_valid <= 1'b1;
        in_op <= next_req.op;
        in_index <= next_req.index;
        in_value <= next_req.value;
        in_row_end <= next_req.row_end;
        gap_left <= quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off that backs up the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (!hold_done && rows_seen >= HOLD_AFTER_ROWS) begin
      out_ready <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= idle_len();
      end
    end
  end

  // Result monitor: each accepted row is checked against the oldest expected row.
  always @(posedge clk) begin : check_rows
    row_result_t want;
    if (rst_n && out_valid && out_ready) begin
      rows_seen <= rows_seen + 1;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d sum %0d", out_row_index, out_row_sum));
      end else begin
        want = expected_rows.pop_front();
        if (out_row_index !== want.row_index) begin
          report_mismatch($sformatf("row_index %0d, want %0d", out_row_index, want.row_index));
        end
        if (out_row_sum !== want.row_sum) begin
          report_mismatch($sformatf("row %0d row_sum %0d, want %0d",
                                    want.row_index, out_row_sum, want.row_sum));
        end
        if (out_saturated !== want.saturated) begin
          report_mismatch($sformatf("row %0d saturated %0b, want %0b",
                                    want.row_index, out_saturated, want.saturated));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned sel;
    int unsigned n;

    // Empty row straight after reset, then an unused opcode that must do nothing.
    add_request(spmv_pkg::OP_EMPTY, 10'd0, 32'sd0, 1'b0);
    add_request(OP_UNUSED, 10'h3FF, 32'shFFFFFFFF, 1'b1);
    // Vector extremes and a few plain values: 1.0, -1.0, the smallest step, -1 LSB.
    add_request(spmv_pkg::OP_LOAD, 10'd0, 32'sh7FFFFFFF, 1'b0);
    add_request(spmv_pkg::OP_LOAD, 10'd1023, 32'sh80000000, 1'b1);
    add_request(spmv_pkg::OP_LOAD, 10'd1, 32'sh00010000, 1'b0);
    add_request(spmv_pkg::OP_LOAD, 10'd2, 32'shFFFF0000, 1'b0);
    add_request(spmv_pkg::OP_LOAD, 10'd3, 32'sh00000001, 1'b0);
    add_request(spmv_pkg::OP_LOAD, 10'd512, 32'shFFFFFFFF, 1'b0);
    // Single-entry rows: plain product, floor of a tiny negative, tiny positive, both clips.
    add_request(spmv_pkg::OP_NZ, 10'd2, 32'sh00018000, 1'b1);
    add_request(spmv_pkg::OP_NZ, 10'd3, 32'shFFFFFFFF, 1'b1);
    add_request(spmv_pkg::OP_NZ, 10'd3, 32'sh00000001, 1'b1);
    add_request(spmv_pkg::OP_NZ, 10'd0, 32'sh7FFFFFFF, 1'b1);
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh7FFFFFFF, 1'b1);
    // Accumulator driven past its positive and then its negative bound.
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh80000000, 1'b0);
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh80000000, 1'b0);
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh80000000, 1'b1);
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh7FFFFFFF, 1'b0);
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh7FFFFFFF, 1'b0);
    add_request(spmv_pkg::OP_NZ, 10'd1023, 32'sh7FFFFFFF, 1'b1);
    // A partial sum discarded by an empty row, with an ignored opcode in between.
    add_request(spmv_pkg::OP_NZ, 10'd1, 32'sh00050000, 1'b0);
    add_request(OP_UNUSED, 10'd1, 32'sh00010000, 1'b1);
    add_request(spmv_pkg::OP_EMPTY, 10'd7, 32'sh12345678, 1'b1);
    add_request(spmv_pkg::OP_NZ, 10'd512, 32'sd0, 1'b1);
    // A load in the middle of a row clears the sum and the row count.
    add_request(spmv_pkg::OP_NZ, 10'd1, 32'sh00020000, 1'b0);
    add_request(spmv_pkg::OP_LOAD, 10'd4, 32'sh00030000, 1'b0);
    add_request(spmv_pkg::OP_NZ, 10'd4, 32'sh00020000, 1'b1);

    // A fresh load followed by one real row over it.
    add_request(spmv_pkg::OP_LOAD, 10'd5, pick_value(), 1'b0);
    add_request(spmv_pkg::OP_NZ, 10'd5, pick_value(), 1'b1);

    // Random part: mostly well-formed rows over loaded columns, some reloads and noise.
    generated = 0;
    while (generated < RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          add_request(spmv_pkg::OP_LOAD, pick_index(), pick_value(),
                      ($urandom_range(0, 1) != 0));
        end
      end else if (sel < 80) begin
        n = $urandom_range(0, 6);
        if (n == 0) begin
          add_request(spmv_pkg::OP_EMPTY, pick_index(), $urandom,
                      ($urandom_range(0, 1) != 0));
        end
        for (int k = 0; k < n; k++) begin
          add_request(spmv_pkg::OP_NZ, pick_column(), pick_value(), k == n - 1);
        end
      end else if (sel < 92) begin
        // Broken row: the partial sum is cut off by an empty row or a reload.
        n = $urandom_range(1, 4);
        repeat (n) begin
          add_request(spmv_pkg::OP_NZ, pick_column(), pick_value(), 1'b0);
        end
        if ($urandom_range(0, 1) == 0) begin
          add_request(spmv_pkg::OP_EMPTY, pick_index(), $urandom, 1'b0);
        end else begin
          add_request(spmv_pkg::OP_LOAD, pick_index(), pick_value(), 1'b0);
        end
      end else begin
        add_request(OP_UNUSED, pick_index(), $urandom, ($urandom_range(0, 1) != 0));
      end
    end
    total_requests = request_fifo.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every expected row to arrive.
    while (taken_requests < total_requests) @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
